// ===== src/dmpr_pkg.sv =====
// Package for the dual motor PWM ramp block: widths, reset values,
// register indexes and the configuration record.
// No dependencies.
`default_nettype none

package dmpr_pkg;

    // Default widths of duty and speed
    localparam int DUTY_BITS_DEF  = 10;
    localparam int SPEED_BITS_DEF = 12;

    // Configuration register widths
    localparam int TIMEOUT_W  = 16;
    localparam int STEP_W     = 10;
    localparam int GAIN_W     = 12;
    localparam int OFFSET_W   = 10;
    localparam int DEADBAND_W = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Speed is Q2.10, so the gain product drops ten fraction bits
    localparam int GAIN_SHIFT = 10;

    // Silence counter
    localparam int SILENCE_W = 16;

    // Reset values of the registers
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd160;
    localparam logic [STEP_W-1:0]     STEP_RST     = 10'd30;
    localparam logic [GAIN_W-1:0]     GAIN_RST     = 12'd910;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 10'd45;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 10'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT  = 3'd0,
        CFG_STEP     = 3'd1,
        CFG_GAIN     = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_DEADBAND = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        REQ_COMMAND = 1'b0,
        REQ_TICK    = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0]  timeout_ticks;
        logic [STEP_W-1:0]     ramp_step;
        logic [GAIN_W-1:0]     duty_gain;
        logic [OFFSET_W-1:0]   duty_offset;
        logic [DEADBAND_W-1:0] deadband;
    } dmpr_cfg_t;

endpackage

`default_nettype wire

// ===== src/dmpr_if.sv =====
// Valid/ready channel interfaces of the dual motor PWM ramp block:
// request, result and configuration write.
// Depends on dmpr_pkg.
`default_nettype none

interface dmpr_req_if #(
    parameter int SPEED_BITS = dmpr_pkg::SPEED_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [SPEED_BITS-1:0] left_speed;
    logic signed [SPEED_BITS-1:0] right_speed;

    modport source (output valid, req_type, left_speed, right_speed, input ready);
    modport sink   (input valid, req_type, left_speed, right_speed, output ready);
endinterface

interface dmpr_res_if #(
    parameter int DUTY_BITS = dmpr_pkg::DUTY_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 left_forward;
    logic [DUTY_BITS-1:0] left_duty;
    logic                 right_forward;
    logic [DUTY_BITS-1:0] right_duty;
    logic                 command_lost;

    modport source (output valid, left_forward, left_duty, right_forward, right_duty,
                    command_lost, input ready);
    modport sink   (input valid, left_forward, left_duty, right_forward, right_duty,
                    command_lost, output ready);
endinterface

interface dmpr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dmpr_pkg::CFG_IDX_W-1:0]  index;
    logic [dmpr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/dmpr_channel.sv =====
// One motor channel: direction latch, scaled duty with offset and
// saturation, slew-limited step and deadband. Purely combinational.
// Depends on dmpr_pkg.
`default_nettype none

module dmpr_channel #(
    parameter int DUTY_BITS  = dmpr_pkg::DUTY_BITS_DEF,
    parameter int SPEED_BITS = dmpr_pkg::SPEED_BITS_DEF
) (
    input  dmpr_pkg::dmpr_cfg_t          cfg,
    input  logic signed [SPEED_BITS-1:0] target,
    input  logic                         dir,
    input  logic [DUTY_BITS-1:0]         level,
    output logic                         dir_next,
    output logic [DUTY_BITS-1:0]         level_next
);
    import dmpr_pkg::*;

    localparam int PROD_W  = GAIN_W + SPEED_BITS;
    localparam int SCALE_W = PROD_W - GAIN_SHIFT;
    localparam int SUM_W   = ((SCALE_W > OFFSET_W) ? SCALE_W : OFFSET_W) + 1;
    localparam int LVL_W   = ((DUTY_BITS > STEP_W) ? DUTY_BITS : STEP_W) + 1;
    localparam int W       = (SUM_W > LVL_W) ? SUM_W : LVL_W;
    localparam logic [W-1:0] DUTY_MAX_W = {{(W-DUTY_BITS){1'b0}}, {DUTY_BITS{1'b1}}};

    logic [SPEED_BITS-1:0] mag;
    logic [PROD_W-1:0]     prod;
    logic [SCALE_W-1:0]    scaled;
    logic [W-1:0]          sum;
    logic [W-1:0]          wanted;
    logic [W-1:0]          lv;
    logic [W-1:0]          step;
    logic [W-1:0]          dband;
    logic [W-1:0]          lv_new;

    // Direction follows the sign; a zero target keeps the last one
    always_comb
    begin
        if (target[SPEED_BITS-1])
            dir_next = 1'b0;
        else if (target != '0)
            dir_next = 1'b1;
        else
            dir_next = dir;
    end

    // Wanted duty: gain * |speed|, drop fraction bits, add offset, saturate
    always_comb
    begin
        mag    = target[SPEED_BITS-1] ? (~$unsigned(target) + 1'b1) : $unsigned(target);
        prod   = PROD_W'(cfg.duty_gain) * PROD_W'(mag);
        scaled = prod[PROD_W-1:GAIN_SHIFT];
        sum    = W'(scaled) + W'(cfg.duty_offset);
        wanted = (sum > DUTY_MAX_W) ? DUTY_MAX_W : sum;
    end

    // Slew-limited step toward wanted, then deadband
    always_comb
    begin
        lv    = W'(level);
        step  = W'(cfg.ramp_step);
        dband = W'(cfg.deadband);
        if ((lv + step) < wanted)
            lv_new = lv + step;
        else if (lv > (wanted + step))
            lv_new = lv - step;
        else
            lv_new = wanted;
        if ((lv_new < dband) && (wanted < dband))
            lv_new = '0;
        level_next = lv_new[DUTY_BITS-1:0];
    end

endmodule

`default_nettype wire

// ===== src/dual_motor_pwm_ramp.sv =====
// Top level of the dual motor PWM ramp block: input register, command-loss
// watchdog, two channel datapaths, result register, configuration registers.
// Depends on dmpr_pkg, dmpr_if and dmpr_channel.
//
//   Channel  Direction  Payload                                        Transactions
//   req      in         req_type, left_speed, right_speed              command or tick
//   res      out        left/right_forward, left/right_duty, lost      one per tick
//   cfg      in         index, data                                    register write
//
// Requests are taken one per cycle while req.ready is high. A tick's result
// passes from the request register into the result register.
// A command gives no result and updates the targets from the request register.
// If the result register is full and not taken, a tick waits in the request
// register and req.ready drops; a command there never waits. cfg.ready is always high.
// Reset loads the register defaults, zero targets and duty, forward direction.
`default_nettype none

module dual_motor_pwm_ramp #(
    parameter int DUTY_BITS  = dmpr_pkg::DUTY_BITS_DEF,
    parameter int SPEED_BITS = dmpr_pkg::SPEED_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    dmpr_req_if.sink          req,
    dmpr_res_if.source        res,
    dmpr_cfg_if.sink          cfg
);
    import dmpr_pkg::*;

    // Request register
    logic                         in_valid_reg;
    req_type_t                    in_type_reg;
    logic signed [SPEED_BITS-1:0] in_left_reg;
    logic signed [SPEED_BITS-1:0] in_right_reg;

    // Block state
    dmpr_cfg_t                    cfg_reg;
    logic signed [SPEED_BITS-1:0] left_target_reg;
    logic signed [SPEED_BITS-1:0] right_target_reg;
    logic                         left_dir_reg;
    logic                         right_dir_reg;
    logic [DUTY_BITS-1:0]         left_level_reg;
    logic [DUTY_BITS-1:0]         right_level_reg;
    logic [SILENCE_W-1:0]         silence_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         out_lforward_reg;
    logic [DUTY_BITS-1:0]         out_lduty_reg;
    logic                         out_rforward_reg;
    logic [DUTY_BITS-1:0]         out_rduty_reg;
    logic                         out_lost_reg;

    logic                         advance;
    logic                         is_tick;
    logic [SILENCE_W-1:0]         silence_next;
    logic                         lost;
    logic signed [SPEED_BITS-1:0] left_tgt;
    logic signed [SPEED_BITS-1:0] right_tgt;
    logic                         left_dir_next;
    logic                         right_dir_next;
    logic [DUTY_BITS-1:0]         left_level_next;
    logic [DUTY_BITS-1:0]         right_level_next;

    // Handshake: a command never waits for the result side
    assign is_tick   = (in_type_reg == REQ_TICK);
    assign advance   = in_valid_reg && (!is_tick || !out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // Watchdog: saturating silence count, targets zeroed past the timeout
    always_comb
    begin
        silence_next = (silence_reg != '1) ? (silence_reg + 1'b1) : silence_reg;
        lost         = (silence_next > cfg_reg.timeout_ticks);
        left_tgt     = lost ? '0 : left_target_reg;
        right_tgt    = lost ? '0 : right_target_reg;
    end

    // Channel datapaths
    dmpr_channel #(
        .DUTY_BITS  (DUTY_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_left (
        .cfg        (cfg_reg),
        .target     (left_tgt),
        .dir        (left_dir_reg),
        .level      (left_level_reg),
        .dir_next   (left_dir_next),
        .level_next (left_level_next)
    );

    dmpr_channel #(
        .DUTY_BITS  (DUTY_BITS),
        .SPEED_BITS (SPEED_BITS)
    ) u_right (
        .cfg        (cfg_reg),
        .target     (right_tgt),
        .dir        (right_dir_reg),
        .level      (right_level_reg),
        .dir_next   (right_dir_next),
        .level_next (right_level_next)
    );

    // Request register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg  <= req_type_t'(req.req_type);
            in_left_reg  <= req.left_speed;
            in_right_reg <= req.right_speed;
        end
    end

    // State update for commands and ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_target_reg  <= '0;
            right_target_reg <= '0;
            left_dir_reg     <= 1'b1;
            right_dir_reg    <= 1'b1;
            left_level_reg   <= '0;
            right_level_reg  <= '0;
            silence_reg      <= '0;
        end
        else if (advance)
        begin
            if (is_tick)
            begin
                silence_reg      <= silence_next;
                left_target_reg  <= left_tgt;
                right_target_reg <= right_tgt;
                left_dir_reg     <= left_dir_next;
                right_dir_reg    <= right_dir_next;
                left_level_reg   <= left_level_next;
                right_level_reg  <= right_level_next;
            end
            else
            begin
                silence_reg      <= '0;
                left_target_reg  <= in_left_reg;
                right_target_reg <= in_right_reg;
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && is_tick)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && is_tick)
        begin
            out_lforward_reg <= left_dir_next;
            out_lduty_reg    <= left_level_next;
            out_rforward_reg <= right_dir_next;
            out_rduty_reg    <= right_level_next;
            out_lost_reg     <= lost;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.left_forward  = out_lforward_reg;
    assign res.left_duty     = out_lduty_reg;
    assign res.right_forward = out_rforward_reg;
    assign res.right_duty    = out_rduty_reg;
    assign res.command_lost  = out_lost_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.ramp_step     <= STEP_RST;
            cfg_reg.duty_gain     <= GAIN_RST;
            cfg_reg.duty_offset   <= OFFSET_RST;
            cfg_reg.deadband      <= DEADBAND_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_TIMEOUT:  cfg_reg.timeout_ticks <= cfg.data[TIMEOUT_W-1:0];
                CFG_STEP:     cfg_reg.ramp_step     <= cfg.data[STEP_W-1:0];
                CFG_GAIN:     cfg_reg.duty_gain     <= cfg.data[GAIN_W-1:0];
                CFG_OFFSET:   cfg_reg.duty_offset   <= cfg.data[OFFSET_W-1:0];
                CFG_DEADBAND: cfg_reg.deadband      <= cfg.data[DEADBAND_W-1:0];
                default:      ;
            endcase
        end
    end

endmodule

`default_nettype wire
